// ===== hdl/pdev_pkg.sv =====
// Package for the position derivative EMA velocity unit.
// Holds field widths, register indexes, fixed constants and the sequencer state type.
// No dependencies.
`default_nettype none

package pdev_pkg;

  localparam int POS_W      = 16;
  localparam int DELTA_W    = 17;
  localparam int STAMP_W    = 32;
  localparam int GAP_W      = 16;
  localparam int ALPHA_W    = 17;
  localparam int ACC_W      = 40;
  localparam int OUT_W      = 16;
  localparam int SCALE_W    = 10;
  localparam int SCALE      = 1000;
  localparam int OUT_MAX    = 32767;
  localparam int OUT_MIN    = -32768;
  localparam int LANES      = 2;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAP   = 2'd1;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_PREP  = 10'b00_0000_0010,
    ST_DIV   = 10'b00_0000_0100,
    ST_ROUND = 10'b00_0000_1000,
    ST_SAT   = 10'b00_0001_0000,
    ST_DIFF  = 10'b00_0010_0000,
    ST_MUL   = 10'b00_0100_0000,
    ST_SUM   = 10'b00_1000_0000,
    ST_NORM  = 10'b01_0000_0000,
    ST_OUT   = 10'b10_0000_0000
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/position_derivative_ema_velocity_unit.sv =====
// Top level of the position derivative EMA velocity unit.
// Uses pdev_pkg for widths, register indexes and the state type.
// Bit-serial divider and bit-serial alpha multiplier, two lanes (x, y).
//
// Usage:
//   Input stream: one request per position sample; tdata carries x, y and the
//   timestamp, tuser the visibility flag. Output stream: one request per sample
//   with both velocities in mm/s and the estimate-valid flag.
//   Configuration: cfg_wr_en with cfg_addr selects alpha (0) or max gap (1);
//   write only while the unit is idle.
//   Invisible, seeding, stale and over-gap samples go straight to the output
//   state; a derivative passes through prepare, divide, round and saturate,
//   and a blended sample further through difference, multiply, sum and
//   normalise. The divider yields one quotient bit per cycle over the
//   26 + VEL_FRAC_BITS bit numerator, and the blend multiplier takes one
//   alpha bit per cycle; both lanes run side by side.
//   One sample is in work at a time; the next is taken once its result sits in
//   the output register, even while that result waits on out_tready.
//   A stalled receiver holds the result; the unit finishes the next sample and
//   then waits in its output state until the register is free.
//   Reset clears the tracked point, the estimate and restores alpha 26214 and
//   max gap 200 ms.
`default_nettype none

module position_derivative_ema_velocity_unit #(
  parameter int VEL_FRAC_BITS   = 8,
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x_mm [15:0], pos_y_mm [31:16], stamp_ms [63:32]
  input  logic [pdev_pkg::IN_DATA_W-1:0]    in_tdata,
  // seen [0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // vel_x_out [15:0], vel_y_out [31:16]
  output logic [pdev_pkg::OUT_DATA_W-1:0]   out_tdata,
  // estimate_ok [0]
  output logic                              out_tuser,
  input  logic                              cfg_wr_en,
  input  logic [pdev_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pdev_pkg::ALPHA_W-1:0]      cfg_wdata
);

  import pdev_pkg::*;

  localparam int PRODK_W = POS_W + SCALE_W;
  localparam int NUM_W   = PRODK_W + VEL_FRAC_BITS;
  localparam int QR_W    = NUM_W + 1;
  localparam int EXT_W   = (QR_W > ACC_W) ? QR_W : ACC_W;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int A_W     = ALPHA_FRAC_BITS + 1;
  localparam int DIFF_W  = ACC_W + 1;
  localparam int PROD_W  = DIFF_W + A_W;

  localparam logic [EXT_W-1:0]          MAG_LIM = EXT_W'(1) << (ACC_W - 1);
  localparam logic [EXT_W-1:0]          POS_LIM = MAG_LIM - EXT_W'(1);
  localparam logic [ALPHA_W-1:0]        ONE_A   = ALPHA_W'(1) << ALPHA_FRAC_BITS;
  localparam logic signed [PROD_W-1:0]  HALF_A  = PROD_W'(1) <<< (ALPHA_FRAC_BITS - 1);
  localparam logic signed [ACC_W:0]     HALF_V  = (ACC_W + 1)'(1) <<< (VEL_FRAC_BITS - 1);
  localparam logic signed [ACC_W:0]     OUT_HI  = (ACC_W + 1)'(OUT_MAX);
  localparam logic signed [ACC_W:0]     OUT_LO  = (ACC_W + 1)'(OUT_MIN);

  function automatic logic [OUT_W-1:0] to_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W:0] ve;
    logic signed [ACC_W:0] rs;
    logic signed [ACC_W:0] sh;
    logic [OUT_W-1:0]      res;
    ve = (ACC_W + 1)'(v);
    rs = ve + HALF_V - $signed({{ACC_W{1'b0}}, v[ACC_W-1]});
    sh = rs >>> VEL_FRAC_BITS;
    priority if (sh > OUT_HI) begin
      res = OUT_W'(OUT_HI);
    end else if (sh < OUT_LO) begin
      res = OUT_W'(OUT_LO);
    end else begin
      res = OUT_W'(sh);
    end
    return res;
  endfunction

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      seeded_r, seeded_nxt;
  logic                      est_r, est_nxt;
  logic signed [POS_W-1:0]   prev_pos_r [LANES];
  logic signed [POS_W-1:0]   prev_pos_nxt [LANES];
  logic [STAMP_W-1:0]        prev_stamp_r, prev_stamp_nxt;
  logic signed [ACC_W-1:0]   acc_r [LANES];
  logic signed [ACC_W-1:0]   acc_nxt [LANES];
  logic [ALPHA_W-1:0]        alpha_r, alpha_nxt;
  logic [GAP_W-1:0]          gap_r, gap_nxt;

  logic [GAP_W-1:0]          dt_r, dt_nxt;
  logic signed [DELTA_W-1:0] delta_r [LANES];
  logic signed [DELTA_W-1:0] delta_nxt [LANES];
  logic [NUM_W-1:0]          num_r [LANES];
  logic [NUM_W-1:0]          num_nxt [LANES];
  logic [GAP_W-1:0]          rem_r [LANES];
  logic [GAP_W-1:0]          rem_nxt [LANES];
  logic [QR_W-1:0]           qr_r [LANES];
  logic [QR_W-1:0]           qr_nxt [LANES];
  logic signed [ACC_W-1:0]   inst_r [LANES];
  logic signed [ACC_W-1:0]   inst_nxt [LANES];
  logic signed [DIFF_W-1:0]  diff_r [LANES];
  logic signed [DIFF_W-1:0]  diff_nxt [LANES];
  logic signed [PROD_W-1:0]  prod_r [LANES];
  logic signed [PROD_W-1:0]  prod_nxt [LANES];
  logic [A_W-1:0]            a_sh_r, a_sh_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]     out_data_r, out_data_nxt;
  logic                      out_user_r, out_user_nxt;

  logic signed [POS_W-1:0]   pos_in [LANES];
  logic [STAMP_W-1:0]        stamp_in;
  logic [STAMP_W-1:0]        dt_full;
  logic                      in_acc;
  logic                      slot_free;
  logic [GAP_W:0]            trial [LANES];
  logic                      ge [LANES];
  logic [DELTA_W-1:0]        mag [LANES];
  logic [PRODK_W-1:0]        prodk [LANES];
  logic [EXT_W-1:0]          qe [LANES];
  logic signed [PROD_W-1:0]  rs_a [LANES];
  logic signed [PROD_W-1:0]  sh_a [LANES];

  assign pos_in[0] = $signed(in_tdata[POS_W-1:0]);
  assign pos_in[1] = $signed(in_tdata[2*POS_W-1:POS_W]);
  assign stamp_in  = in_tdata[2*POS_W+STAMP_W-1:2*POS_W];
  assign dt_full   = stamp_in - prev_stamp_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    seeded_nxt     = seeded_r;
    est_nxt        = est_r;
    prev_stamp_nxt = prev_stamp_r;
    alpha_nxt      = alpha_r;
    gap_nxt        = gap_r;
    dt_nxt         = dt_r;
    a_sh_nxt       = a_sh_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    for (int l = 0; l < LANES; l++) begin
      prev_pos_nxt[l] = prev_pos_r[l];
      acc_nxt[l]      = acc_r[l];
      delta_nxt[l]    = delta_r[l];
      num_nxt[l]      = num_r[l];
      rem_nxt[l]      = rem_r[l];
      qr_nxt[l]       = qr_r[l];
      inst_nxt[l]     = inst_r[l];
      diff_nxt[l]     = diff_r[l];
      prod_nxt[l]     = prod_r[l];

      trial[l] = {rem_r[l], num_r[l][NUM_W-1]};
      ge[l]    = trial[l] >= {1'b0, dt_r};
      mag[l]   = delta_r[l][DELTA_W-1] ? DELTA_W'(-delta_r[l]) : DELTA_W'(delta_r[l]);
      prodk[l] = PRODK_W'(mag[l][POS_W-1:0]) * PRODK_W'(SCALE);
      qe[l]    = EXT_W'(qr_r[l]);
      rs_a[l]  = prod_r[l] + HALF_A
               - $signed({{(PROD_W-1){1'b0}}, prod_r[l][PROD_W-1]});
      sh_a[l]  = rs_a[l] >>> ALPHA_FRAC_BITS;
    end

    if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_ALPHA: alpha_nxt = cfg_wdata;
        REG_GAP:   gap_nxt   = cfg_wdata[GAP_W-1:0];
        default:   ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_OUT;
          priority if (!in_tuser) begin
            seeded_nxt     = 1'b0;
            est_nxt        = 1'b0;
            prev_stamp_nxt = '0;
            for (int l = 0; l < LANES; l++) begin
              prev_pos_nxt[l] = '0;
              acc_nxt[l]      = '0;
            end
          end else if (!seeded_r) begin
            seeded_nxt     = 1'b1;
            est_nxt        = 1'b0;
            prev_stamp_nxt = stamp_in;
            for (int l = 0; l < LANES; l++) begin
              prev_pos_nxt[l] = pos_in[l];
              acc_nxt[l]      = '0;
            end
          end else if (stamp_in <= prev_stamp_r) begin
            // hold the estimate
          end else if (dt_full > STAMP_W'(gap_r)) begin
            est_nxt        = 1'b0;
            prev_stamp_nxt = stamp_in;
            for (int l = 0; l < LANES; l++) begin
              prev_pos_nxt[l] = pos_in[l];
              acc_nxt[l]      = '0;
            end
          end else begin
            state_nxt      = ST_PREP;
            dt_nxt         = dt_full[GAP_W-1:0];
            prev_stamp_nxt = stamp_in;
            for (int l = 0; l < LANES; l++) begin
              delta_nxt[l]    = DELTA_W'(pos_in[l]) - DELTA_W'(prev_pos_r[l]);
              prev_pos_nxt[l] = pos_in[l];
            end
          end
        end
      end
      ST_PREP: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
        for (int l = 0; l < LANES; l++) begin
          num_nxt[l] = {prodk[l], {VEL_FRAC_BITS{1'b0}}};
          rem_nxt[l] = '0;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        for (int l = 0; l < LANES; l++) begin
          rem_nxt[l] = ge[l] ? GAP_W'(trial[l] - {1'b0, dt_r}) : trial[l][GAP_W-1:0];
          num_nxt[l] = {num_r[l][NUM_W-2:0], ge[l]};
        end
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_nxt = ST_SAT;
        for (int l = 0; l < LANES; l++) begin
          qr_nxt[l] = {1'b0, num_r[l]}
                    + QR_W'({rem_r[l], 1'b0} >= {1'b0, dt_r});
        end
      end
      ST_SAT: begin
        for (int l = 0; l < LANES; l++) begin
          if (delta_r[l][DELTA_W-1]) begin
            inst_nxt[l] = -ACC_W'((qe[l] > MAG_LIM) ? MAG_LIM : qe[l]);
          end else begin
            inst_nxt[l] = ACC_W'((qe[l] > POS_LIM) ? POS_LIM : qe[l]);
          end
        end
        if (est_r) begin
          state_nxt = ST_DIFF;
        end else begin
          state_nxt = ST_OUT;
          est_nxt   = 1'b1;
          for (int l = 0; l < LANES; l++) begin
            acc_nxt[l] = inst_nxt[l];
          end
        end
      end
      ST_DIFF: begin
        state_nxt = ST_MUL;
        cnt_nxt   = '0;
        a_sh_nxt  = (alpha_r > ONE_A) ? A_W'(ONE_A) : alpha_r[A_W-1:0];
        for (int l = 0; l < LANES; l++) begin
          diff_nxt[l] = DIFF_W'(inst_r[l]) - DIFF_W'(acc_r[l]);
          prod_nxt[l] = '0;
        end
      end
      ST_MUL: begin
        cnt_nxt  = cnt_r + CNT_W'(1);
        a_sh_nxt = a_sh_r << 1;
        for (int l = 0; l < LANES; l++) begin
          prod_nxt[l] = (prod_r[l] <<< 1)
                      + (a_sh_r[A_W-1] ? PROD_W'(diff_r[l]) : PROD_W'(0));
        end
        if (cnt_r == CNT_W'(A_W - 1)) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        state_nxt = ST_NORM;
        for (int l = 0; l < LANES; l++) begin
          prod_nxt[l] = prod_r[l] + (PROD_W'(acc_r[l]) <<< ALPHA_FRAC_BITS);
        end
      end
      ST_NORM: begin
        state_nxt = ST_OUT;
        for (int l = 0; l < LANES; l++) begin
          acc_nxt[l] = ACC_W'(sh_a[l]);
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_user_nxt  = est_r;
          out_data_nxt  = est_r ? {to_out(acc_r[1]), to_out(acc_r[0])} : '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      seeded_r     <= 1'b0;
      est_r        <= 1'b0;
      prev_stamp_r <= '0;
      alpha_r      <= ALPHA_W'(26214);
      gap_r        <= GAP_W'(200);
      out_valid_r  <= 1'b0;
      for (int l = 0; l < LANES; l++) begin
        prev_pos_r[l] <= '0;
        acc_r[l]      <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      seeded_r     <= seeded_nxt;
      est_r        <= est_nxt;
      prev_stamp_r <= prev_stamp_nxt;
      alpha_r      <= alpha_nxt;
      gap_r        <= gap_nxt;
      out_valid_r  <= out_valid_nxt;
      for (int l = 0; l < LANES; l++) begin
        prev_pos_r[l] <= prev_pos_nxt[l];
        acc_r[l]      <= acc_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    dt_r       <= dt_nxt;
    a_sh_r     <= a_sh_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    for (int l = 0; l < LANES; l++) begin
      delta_r[l] <= delta_nxt[l];
      num_r[l]   <= num_nxt[l];
      rem_r[l]   <= rem_nxt[l];
      qr_r[l]    <= qr_nxt[l];
      inst_r[l]  <= inst_nxt[l];
      diff_r[l]  <= diff_nxt[l];
      prod_r[l]  <= prod_nxt[l];
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid_r && !out_tready) |=> (state_r == ST_OUT))
    else $error("result dropped while output register busy");

  a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("nonzero velocity without valid estimate");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= CNT_W'(NUM_W - 1)))
    else $error("divider count overrun");

  a_unseen_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=> (state_r == ST_OUT && !est_r && !seeded_r))
    else $error("invisible sample did not clear the track");

  a_valid_needs_seed: assert property (@(posedge clk) disable iff (!rst_n)
    est_r |-> seeded_r)
    else $error("estimate valid without a seeded point");
`endif

endmodule

`default_nettype wire
